/* rtl/ksh_pkg.sv */
// Package for the keyed string hash with hex digest.
// Holds the hash constants, command codes, sequencer and unit op types, and the
// hex digit function. Used by every module under rtl/.
`default_nettype none

package ksh_pkg;

  // Hash constants
  localparam logic [63:0] HASH_INIT    = 64'd5381;
  localparam logic [31:0] GOLDEN_MUL   = 32'h9E37_79B9;
  localparam int          DIGEST_CHARS = 32;
  localparam int          IDX_W        = $clog2(DIGEST_CHARS);
  // Highest hash bit the digest reads is 2*15+7
  localparam int          SNAP_W       = 38;
  localparam int          SH_W         = 6;

  // Command codes carried on in_tuser
  localparam logic [1:0] CMD_KEY = 2'd0;
  localparam logic [1:0] CMD_MSG = 2'd1;
  localparam logic [1:0] CMD_FIN = 2'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIX,
    ST_ROT,
    ST_MLO,
    ST_MHI
  } state_t;

  // Operations of the shared arithmetic unit
  typedef enum logic [1:0] {
    OP_MIX,
    OP_ROT,
    OP_MLO,
    OP_MHI
  } alu_op_t;

  // Digest launch from the sequencer to the emitter
  typedef struct packed {
    logic              start;
    logic [SNAP_W-1:0] snap;
  } dig_start_t;

  // Lowercase ASCII hex digit
  function automatic logic [6:0] hex_digit(input logic [3:0] nib);
    logic [6:0] wide;
    wide = {3'b000, nib};
    if (nib < 4'd10) begin
      hex_digit = 7'h30 + wide;
    end else begin
      hex_digit = 7'h57 + wide;
    end
  endfunction

endpackage

`default_nettype wire

/* rtl/ksh_alu.sv */
// Shared arithmetic unit: mix step, shift-or step and the two halves of the
// 64x32 constant multiply on one 32x32 multiplier. Depends on ksh_pkg.
`default_nettype none

module ksh_alu
  import ksh_pkg::*;
(
  input  alu_op_t     op,
  input  logic [63:0] hash,
  input  logic [63:0] part,
  input  logic [7:0]  byte_in,
  output logic [63:0] result
);

  logic [63:0] sext;
  logic [31:0] mul_a;
  logic [63:0] prod;
  logic [31:0] upper;

  assign sext = {{56{byte_in[7]}}, byte_in};

  // One 32x32 multiplier, low half of the hash first, then the high half
  assign mul_a = (op == OP_MHI) ? hash[63:32] : hash[31:0];
  assign prod  = {32'd0, mul_a} * {32'd0, GOLDEN_MUL};
  assign upper = part[63:32] + prod[31:0];

  always_comb begin
    unique case (op)
      OP_MIX: result = ((hash << 5) + hash) ^ sext;
      OP_ROT: result = (hash << 13) | (hash >> 19);
      OP_MLO: result = prod;
      OP_MHI: result = {upper, part[31:0]};
      default: result = hash;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/ksh_digest.sv */
// Digest emitter: walks a snapshot of the hash and sends 32 hex characters
// through a registered output stage. Depends on ksh_pkg.
`default_nettype none

module ksh_digest
  import ksh_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  dig_start_t launch,
  output logic       busy,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic       out_tlast
);

  logic [SNAP_W-1:0] snap_r;
  logic [IDX_W-1:0]  idx_r;
  logic              busy_r;
  logic              valid_r;
  logic [6:0]        char_r;
  logic              last_r;
  logic [SH_W-1:0]   sh;
  logic [SNAP_W-1:0] shifted;
  logic              load;

  // Character j takes byte j/2 at bit 2*(j/2); high nibble first
  assign sh      = {1'b0, idx_r[IDX_W-1:1], 1'b0} + (idx_r[0] ? 6'd0 : 6'd4);
  assign shifted = snap_r >> sh;
  assign load    = busy_r && (!valid_r || out_tready);

  // Walk state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (launch.start) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (load) begin
      idx_r <= idx_r + 1'b1;
      if (idx_r == IDX_W'(DIGEST_CHARS - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (launch.start) begin
      snap_r <= launch.snap;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      char_r <= hex_digit(shifted[3:0]);
      last_r <= (idx_r == IDX_W'(DIGEST_CHARS - 1));
    end
  end

  assign busy       = busy_r;
  assign out_tvalid = valid_r;
  assign out_tdata  = {1'b0, char_r};
  assign out_tlast  = last_r;

endmodule

`default_nettype wire

/* rtl/keyed_string_hash_hex.sv */
// Top level of the keyed string hash: sequencer, hash register, shared unit
// and digest emitter. Depends on ksh_pkg, ksh_alu and ksh_digest.
//
//  channel | direction | tdata                 | tuser        | tlast
//  in_     | slave     | [7:0] byte_value      | [1:0] command| -
//  out_    | master    | [6:0] hex_char, [7] 0 | -            | last
//
// A key byte is accepted, then mixed; a message byte is accepted, then takes
// the mix, shift-or, low and high half of the constant multiply on the one
// 32x32 multiplier in that order. A finish is accepted, then the emitter sends
// 32 beats, one a cycle while out_tready is high; in_tready stays low until
// the last beat is loaded. Reset sets the hash to 5381 and empties the output
// stage. An unused command is taken and dropped.
`default_nettype none

module keyed_string_hash_hex
  import ksh_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] byte_value
  input  logic [1:0] in_tuser,   // [1:0] command
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [6:0] hex_char, [7] zero
  output logic       out_tlast
);

  state_t      state_r, state_nxt;
  logic [63:0] hash_r;
  logic [63:0] part_r;
  logic [7:0]  byte_r;
  logic        msg_r;
  alu_op_t     op;
  logic [63:0] alu_res;
  logic        dig_busy;
  dig_start_t  launch;
  logic        accept;

  assign in_tready = (state_r == ST_IDLE) && !dig_busy;
  assign accept    = in_tvalid && in_tready;

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op        = OP_MIX;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_tuser == CMD_KEY || in_tuser == CMD_MSG)) begin
          state_nxt = ST_MIX;
        end
      end
      ST_MIX: begin
        op        = OP_MIX;
        state_nxt = msg_r ? ST_ROT : ST_IDLE;
      end
      ST_ROT: begin
        op        = OP_ROT;
        state_nxt = ST_MLO;
      end
      ST_MLO: begin
        op        = OP_MLO;
        state_nxt = ST_MHI;
      end
      ST_MHI: begin
        op        = OP_MHI;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Latch the beat
  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_tdata;
      msg_r  <= (in_tuser == CMD_MSG);
    end
  end

  // Hash register; finish snapshots it and starts again from the seed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= HASH_INIT;
    end else if (accept && in_tuser == CMD_FIN) begin
      hash_r <= HASH_INIT;
    end else if (state_r == ST_MIX || state_r == ST_ROT || state_r == ST_MHI) begin
      hash_r <= alu_res;
    end
  end

  // Low partial product
  always_ff @(posedge clk) begin
    if (state_r == ST_MLO) begin
      part_r <= alu_res;
    end
  end

  assign launch.start = accept && (in_tuser == CMD_FIN);
  assign launch.snap  = hash_r[SNAP_W-1:0];

  ksh_alu u_alu (
    .op      (op),
    .hash    (hash_r),
    .part    (part_r),
    .byte_in (byte_r),
    .result  (alu_res)
  );

  ksh_digest u_digest (
    .clk        (clk),
    .rst_n      (rst_n),
    .launch     (launch),
    .busy       (dig_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

/* rtl/ksh_checker.sv */
// Port-level checks for keyed_string_hash_hex, bound onto the top level.
// Sees only the top-level ports; takes the command codes from ksh_pkg.
`default_nettype none

module ksh_checker
  import ksh_pkg::*;
(
  input wire       clk,
  input wire       rst_n,
  input wire       in_tvalid,
  input wire       in_tready,
  input wire [1:0] in_tuser,
  input wire       out_tvalid,
  input wire       out_tready,
  input wire [7:0] out_tdata,
  input wire       out_tlast
);

  // Stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output beat changed under stall");

  // Every beat is a lowercase hex digit
  a_hex_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata >= 8'h30 && out_tdata <= 8'h39) ||
                   (out_tdata >= 8'h61 && out_tdata <= 8'h66))
    else $error("output beat is not a hex digit");

  // A used command keeps the input closed on the next cycle
  a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready &&
    (in_tuser == CMD_KEY || in_tuser == CMD_MSG || in_tuser == CMD_FIN) |=> !in_tready)
    else $error("input taken while previous beat still in work");

  // A finish cannot be followed by output quietly absent
  a_fin_emits: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == CMD_FIN |=> ##1 out_tvalid)
    else $error("finish gave no digest beat");

  // Reset empties the output stage
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid straight after reset");

endmodule

bind keyed_string_hash_hex ksh_checker u_ksh_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire
